[src/assert_macros.svh]
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

[src/hte_pkg.sv]
package hte_pkg;

  localparam int unsigned MAX_RUN   = 7;
  localparam int unsigned RUN_LEN_W = 3;

  typedef logic [MAX_RUN-1:0][7:0] run_bytes_t;
  typedef logic [RUN_LEN_W-1:0]    run_len_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_final;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_word_t;

  // decoded run of output bytes, byte 0 goes out first
  typedef struct packed {
    run_bytes_t bytes;
    run_len_t   len;
    logic       held_next;
  } run_t;

  localparam logic [7:0] BYTE_AMP   = 8'h26;
  localparam logic [7:0] BYTE_LT    = 8'h3c;
  localparam logic [7:0] BYTE_GT    = 8'h3e;
  localparam logic [7:0] BYTE_QUOTE = 8'h22;
  localparam logic [7:0] BYTE_C2    = 8'hc2;
  localparam logic [7:0] BYTE_A0    = 8'ha0;

  localparam run_bytes_t ENT_AMP  = {8'h00, 8'h00, ";", "p", "m", "a", "&"};
  localparam run_bytes_t ENT_LT   = {8'h00, 8'h00, 8'h00, ";", "t", "l", "&"};
  localparam run_bytes_t ENT_GT   = {8'h00, 8'h00, 8'h00, ";", "t", "g", "&"};
  localparam run_bytes_t ENT_QUOT = {8'h00, ";", "t", "o", "u", "q", "&"};
  localparam run_bytes_t ENT_NBSP = {8'h00, ";", "p", "s", "b", "n", "&"};

  localparam run_len_t LEN_AMP  = 3'd5;
  localparam run_len_t LEN_LT   = 3'd4;
  localparam run_len_t LEN_GT   = 3'd4;
  localparam run_len_t LEN_QUOT = 3'd6;
  localparam run_len_t LEN_NBSP = 3'd6;

endpackage

[src/hte_decode.sv]
module hte_decode
  import hte_pkg::*;
(
  input  in_word_t word,
  input  logic     held,
  input  logic     quote_esc,
  output run_t     run
);

  run_bytes_t ent;
  run_len_t   ent_len;
  logic       prefix;
  logic       held_next;

  always_comb begin
    ent       = '0;
    ent_len   = '0;
    prefix    = 1'b0;
    held_next = 1'b0;
    if (held && word.in_byte == BYTE_A0) begin
      ent     = ENT_NBSP;
      ent_len = LEN_NBSP;
    end else begin
      // a held c2 that did not pair up goes out ahead of this byte
      prefix = held;
      unique case (word.in_byte)
        BYTE_AMP: begin
          ent     = ENT_AMP;
          ent_len = LEN_AMP;
        end
        BYTE_LT: begin
          ent     = ENT_LT;
          ent_len = LEN_LT;
        end
        BYTE_GT: begin
          ent     = ENT_GT;
          ent_len = LEN_GT;
        end
        BYTE_QUOTE: begin
          if (quote_esc) begin
            ent     = ENT_QUOT;
            ent_len = LEN_QUOT;
          end else begin
            ent[0]  = word.in_byte;
            ent_len = 3'd1;
          end
        end
        BYTE_C2: begin
          if (word.in_final) begin
            ent[0]  = word.in_byte;
            ent_len = 3'd1;
          end else begin
            held_next = 1'b1;
          end
        end
        default: begin
          ent[0]  = word.in_byte;
          ent_len = 3'd1;
        end
      endcase
    end
  end

  assign run.bytes     = prefix ? {ent[MAX_RUN-2:0], BYTE_C2} : ent;
  assign run.len       = ent_len + {{(RUN_LEN_W-1){1'b0}}, prefix};
  assign run.held_next = held_next;

endmodule

[src/hte_serializer.sv]
`include "assert_macros.svh"

module hte_serializer
  import hte_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  run_t      run,
  input  logic      fin,
  output logic      free,
  output logic      dst_valid,
  input  logic      dst_stall,
  output out_word_t dst_word
);

  logic       run_valid;
  run_bytes_t bytes;
  run_len_t   len;
  run_len_t   pos;
  logic       run_fin;
  logic       last;

  assign last = (pos == len - 3'd1);
  // buffer frees up in the same cycle its last word is taken
  assign free = !run_valid || (last && !dst_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      pos       <= '0;
    end else if (load && free) begin
      run_valid <= 1'b1;
      pos       <= '0;
    end else if (run_valid && !dst_stall) begin
      if (last) begin
        run_valid <= 1'b0;
      end else begin
        pos <= pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      bytes   <= run.bytes;
      len     <= run.len;
      run_fin <= fin;
    end
  end

  assign dst_valid           = run_valid;
  assign dst_word.out_byte   = bytes[pos];
  assign dst_word.run_last   = last;
  assign dst_word.string_end = last && run_fin;

  `ASSERT_CLK(a_pos_in_run, clk, rst, run_valid |-> (pos < len))
  `ASSERT_NEVER(a_empty_run, clk, rst, run_valid && len == '0)
  `ASSERT_CLK(a_run_continues, clk, rst, (run_valid && !dst_stall && !last) |=> run_valid)
  `ASSERT_NEVER(a_load_empty, clk, rst, load && run.len == '0)

endmodule

[src/html_text_escaper_core.sv]
// channel  direction  handshake            word
// src      in         src_valid/src_stall  in_word_t  (one string byte + final flag)
// dst      out        dst_valid/dst_stall  out_word_t (one escaped byte + run/string flags)
// cfg      in         cfg_valid/cfg_ready  quote escape enable bit, always ready
//
// a byte is taken every cycle while each one yields at most one output word and dst
// does not stall; an entity run of up to 7 words stalls the source side until its
// last word is taken; an accepted byte is registered in s1_word, decoded and loaded
// into the run buffer in hte_serializer, which sets the rate: one output word per
// cycle while dst does not stall; reset clears both stages and drops a pending c2;
// quote escaping resets to on; dst stall freezes the run buffer and backs up into src_stall
module html_text_escaper_core
  import hte_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_stall,
  input  in_word_t  src_word,
  output logic      dst_valid,
  input  logic      dst_stall,
  output out_word_t dst_word,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic     s1_valid;
  in_word_t s1_word;
  logic     held_c2;
  logic     quote_esc;
  logic     s2_free;
  logic     s1_move;
  logic     load;
  run_t     run;

  assign cfg_ready = 1'b1;
  assign s1_move   = s1_valid && s2_free;
  assign src_stall = s1_valid && !s2_free;
  // a non-final c2 with nothing pending produces no words
  assign load      = s1_move && (run.len != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_esc <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      quote_esc <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      held_c2  <= 1'b0;
    end else begin
      if (src_valid && !src_stall) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        held_c2 <= run.held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      s1_word <= src_word;
    end
  end

  hte_decode u_decode (
    .word      (s1_word),
    .held      (held_c2),
    .quote_esc (quote_esc),
    .run       (run)
  );

  hte_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .run       (run),
    .fin       (s1_word.in_final),
    .free      (s2_free),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word)
  );

endmodule
